>>> src/iepc_pkg.sv
// Shared types and constants for the interrupt enable and pending controller.
// Used by iepc_core and irq_enable_pending_controller; depends on nothing.
`default_nettype none

package iepc_pkg;

  // Operation carried by one input transfer.
  typedef enum logic [2:0] {
    KIND_BUS_WRITE   = 3'd0,
    KIND_BUS_READ    = 3'd1,
    KIND_SIGNAL_IRQ  = 3'd2,
    KIND_SIGNAL_BASE = 3'd3,
    KIND_CLEAR_IRQ   = 3'd4,
    KIND_CLEAR_BASE  = 3'd5
  } kind_t;

  // Word register indexes in the usual order of the scheme.
  localparam logic [3:0] REG_BASIC_PENDING = 4'd0;
  localparam logic [3:0] REG_PENDING_1     = 4'd1;
  localparam logic [3:0] REG_PENDING_2     = 4'd2;
  localparam logic [3:0] REG_ENABLE_1      = 4'd4;
  localparam logic [3:0] REG_ENABLE_2      = 4'd5;
  localparam logic [3:0] REG_ENABLE_BASIC  = 4'd6;
  localparam logic [3:0] REG_DISABLE_1     = 4'd7;
  localparam logic [3:0] REG_DISABLE_2     = 4'd8;
  localparam logic [3:0] REG_DISABLE_BASIC = 4'd9;

  // Sources that exist: bits 29, 43, 45, 46, 48 to 55 and 57.
  localparam logic [63:0] IMPLEMENTED_IRQS = 64'h02FF_6800_2000_0000;
  // GPIO bank 3 enable also covers banks 0 to 2.
  localparam int unsigned GPIO_BANK3_BIT   = 52;
  localparam logic [63:0] GPIO_LOW_BANKS   = 64'h000E_0000_0000_0000;

  // One input item as held in the input register.
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  register_index;
    logic [31:0] write_data;
    logic [5:0]  source_number;
    logic        cpu_irq_masked;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_request;
  } result_t;

endpackage

`default_nettype wire

>>> src/iepc_core.sv
// State and single-pass update logic of the interrupt controller: word
// registers, enable bits and pending flags. Depends on iepc_pkg.
`default_nettype none

module iepc_core #(
  parameter int NUM_REGISTERS = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire iepc_pkg::item_t  item,
  output iepc_pkg::result_t     result
);

  localparam int IDX_W = $clog2(NUM_REGISTERS);

  logic [31:0] words_r   [NUM_REGISTERS];
  logic [31:0] words_nxt [NUM_REGISTERS];
  logic [63:0] en_r, en_nxt;
  logic [63:0] pend_r, pend_nxt;
  logic [7:0]  ben_r, ben_nxt;
  logic [7:0]  bpend_r, bpend_nxt;

  logic             idx_ok;
  logic [IDX_W-1:0] widx;
  logic [63:0]      src_bit;
  logic [63:0]      en_eff;
  logic [63:0]      sel;
  logic             src_basic;
  logic [7:0]       bsrc_bit;
  logic [31:0]      rd;

  assign idx_ok    = ({1'b0, item.register_index} < 5'(NUM_REGISTERS));
  assign widx      = item.register_index[IDX_W-1:0];
  assign src_bit   = 64'd1 << item.source_number;
  assign src_basic = (item.source_number[5:3] == 3'd0);
  assign bsrc_bit  = 8'd1 << item.source_number[2:0];
  assign en_eff    = en_r[iepc_pkg::GPIO_BANK3_BIT] ? (en_r | iepc_pkg::GPIO_LOW_BANKS) : en_r;

  // Next state and read data for the item in the input register.
  always_comb begin
    words_nxt = words_r;
    en_nxt    = en_r;
    pend_nxt  = pend_r;
    ben_nxt   = ben_r;
    bpend_nxt = bpend_r;
    rd        = 32'd0;
    sel       = 64'd0;
    case (item.kind)
      iepc_pkg::KIND_BUS_WRITE: begin
        if (idx_ok) begin
          words_nxt[widx] = item.write_data;
          case (item.register_index)
            iepc_pkg::REG_ENABLE_1, iepc_pkg::REG_DISABLE_1: begin
              sel = {32'd0, item.write_data} & iepc_pkg::IMPLEMENTED_IRQS;
              words_nxt[widx] = 32'd0;
            end
            iepc_pkg::REG_ENABLE_2, iepc_pkg::REG_DISABLE_2: begin
              sel = {item.write_data, 32'd0} & iepc_pkg::IMPLEMENTED_IRQS;
              words_nxt[widx] = 32'd0;
            end
            iepc_pkg::REG_ENABLE_BASIC: begin
              ben_nxt = ben_r | item.write_data[7:0];
              words_nxt[widx] = 32'd0;
            end
            iepc_pkg::REG_DISABLE_BASIC: begin
              ben_nxt = ben_r & ~item.write_data[7:0];
              words_nxt[widx] = 32'd0;
            end
            default: ;
          endcase
          if ((item.register_index == iepc_pkg::REG_ENABLE_1) ||
              (item.register_index == iepc_pkg::REG_ENABLE_2)) begin
            en_nxt = en_r | sel;
          end else begin
            en_nxt = en_r & ~sel;
          end
        end
      end
      iepc_pkg::KIND_BUS_READ: begin
        if (idx_ok) begin
          rd = words_r[widx];
        end
      end
      iepc_pkg::KIND_SIGNAL_IRQ: begin
        if (!item.cpu_irq_masked && ((en_eff & src_bit) != 64'd0)) begin
          if (item.source_number[5]) begin
            words_nxt[IDX_W'(iepc_pkg::REG_PENDING_2)] =
              words_r[IDX_W'(iepc_pkg::REG_PENDING_2)] | src_bit[63:32];
          end else begin
            words_nxt[IDX_W'(iepc_pkg::REG_PENDING_1)] =
              words_r[IDX_W'(iepc_pkg::REG_PENDING_1)] | src_bit[31:0];
          end
          pend_nxt = pend_r | src_bit;
        end
      end
      iepc_pkg::KIND_SIGNAL_BASE: begin
        if (src_basic && !item.cpu_irq_masked && ((ben_r & bsrc_bit) != 8'd0)) begin
          words_nxt[IDX_W'(iepc_pkg::REG_BASIC_PENDING)] =
            words_r[IDX_W'(iepc_pkg::REG_BASIC_PENDING)] | {24'd0, bsrc_bit};
          bpend_nxt = bpend_r | bsrc_bit;
        end
      end
      iepc_pkg::KIND_CLEAR_IRQ: begin
        pend_nxt = pend_r & ~src_bit;
      end
      iepc_pkg::KIND_CLEAR_BASE: begin
        if (src_basic) begin
          bpend_nxt = bpend_r & ~bsrc_bit;
        end
      end
      default: ;
    endcase
  end

  // The request reflects the flags as they stand after this item.
  assign result.read_data   = rd;
  assign result.irq_request = !item.cpu_irq_masked &&
                              ((pend_nxt != 64'd0) || (bpend_nxt != 8'd0));

  // State update, one item per cycle when fire is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGISTERS; i++) begin
        words_r[i] <= 32'd0;
      end
      en_r    <= 64'd0;
      pend_r  <= 64'd0;
      ben_r   <= 8'd0;
      bpend_r <= 8'd0;
    end else if (fire) begin
      words_r <= words_nxt;
      en_r    <= en_nxt;
      pend_r  <= pend_nxt;
      ben_r   <= ben_nxt;
      bpend_r <= bpend_nxt;
    end
  end

`ifndef SYNTH
  // A clear event leaves the addressed flag low.
  a_clear_drops_flag: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.kind == iepc_pkg::KIND_CLEAR_IRQ)
    |=> !pend_r[$past(item.source_number)])
    else $error("pending flag survived a clear");

  // A masked signal never raises a pending flag.
  a_masked_signal_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.cpu_irq_masked && (item.kind == iepc_pkg::KIND_SIGNAL_IRQ)
    |=> pend_r == $past(pend_r))
    else $error("masked signal changed the pending flags");

  // Only implemented sources can ever be enabled or pending.
  a_only_implemented: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> ((en_r | pend_r) & ~iepc_pkg::IMPLEMENTED_IRQS) == 64'd0)
    else $error("unimplemented source enabled or pending");
`endif

endmodule

`default_nettype wire

>>> src/irq_enable_pending_controller.sv
// Top level of the interrupt enable and pending controller: input register,
// result register and handshakes. Depends on iepc_pkg and iepc_core.
`default_nettype none

// One item per clock cycle is accepted and retired as long as the output is
// not stalled; each item passes the input register and then the result register.
// The rate is set by the single-pass update of the controller state (word
// registers, enable bits and pending flags) between the input register and
// the result register. Every transfer on the input gives exactly one result:
// read data on a bus read (zero otherwise) and the processor request line
// as it stands after the item.
module irq_enable_pending_controller #(
  parameter int NUM_REGISTERS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_kind,
  input  wire logic [3:0]  in_register_index,
  input  wire logic [31:0] in_write_data,
  input  wire logic [5:0]  in_source_number,
  input  wire logic        in_cpu_irq_masked,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_read_data,
  output logic             out_irq_request
);

  logic                s1_valid_r, s1_valid_nxt;
  iepc_pkg::item_t     s1_item_r;
  logic                out_valid_r, out_valid_nxt;
  iepc_pkg::result_t   out_res_r;
  iepc_pkg::result_t   core_res;
  logic                advance;
  logic                fire;
  logic                in_take;

  // The input register moves on whenever the result register is free or
  // being emptied in this cycle.
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_valid_r && !out_stall ? 1'b0 : out_valid_r);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.kind           <= iepc_pkg::kind_t'(in_kind);
      s1_item_r.register_index <= in_register_index;
      s1_item_r.write_data     <= in_write_data;
      s1_item_r.source_number  <= in_source_number;
      s1_item_r.cpu_irq_masked <= in_cpu_irq_masked;
    end
    if (fire) begin
      out_res_r <= core_res;
    end
  end

  iepc_core #(
    .NUM_REGISTERS (NUM_REGISTERS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .result (core_res)
  );

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_res_r.read_data;
  assign out_irq_request = out_res_r.irq_request;

`ifndef SYNTH
  // An item waiting in the input register is never dropped.
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("input item lost while the result register was full");

  // Every processed item lands in the result register.
  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed item gave no result");

  // A new transfer is only taken when the input register is empty or moves on.
  a_take_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> (!s1_valid_r || fire))
    else $error("input transfer overwrote a waiting item");
`endif

endmodule

`default_nettype wire
